// ===== src/pscg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pscg_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_INC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_GAIN = 2'd2;

  localparam int unsigned INC_W  = 32;
  localparam int unsigned GAIN_W = 16;

  localparam logic [INC_W-1:0]  PHASE_INC_RST = 32'd8544566;
  localparam logic [INC_W-1:0]  PULSE_INC_RST = 32'd34178;
  localparam logic [GAIN_W-1:0] TONE_GAIN_RST = 16'd21627;

  // Quarter-wave table generation: pi in Q2.30, Taylor terms
  localparam longint unsigned PI_Q30       = 64'd3373259426;
  localparam int unsigned     TAYLOR_TERMS = 8;

endpackage

`default_nettype wire

// ===== src/pscg_sine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Quarter-wave sine lookup, one request per cycle, result registered for the next cycle.
module pscg_sine #(
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  wire logic                          clk_i,
  input  wire logic [PHASE_BITS-1:0]         phase_i,
  output logic signed [SAMPLE_BITS-1:0]      sine_o
);

  localparam int unsigned QW    = PHASE_BITS - 2;
  localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned MAG_W = SAMPLE_BITS - 1;
  localparam int unsigned SC_W  = QW + IDX_W + 1;
  localparam longint unsigned SineAmp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam longint unsigned XDiv    = 64'd4 * SINE_TABLE_DEPTH;

  // Taylor divisors (2n)*(2n+1) for n = 1..8
  localparam longint unsigned TaylorDiv [pscg_pkg::TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // Entry k = sin((2k+1)*pi/(4*depth)) * amp, Taylor series in Q2.30
  function automatic longint unsigned quarter_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    begin
      x    = ((2 * longint'(k) + 1) * pscg_pkg::PI_Q30) / XDiv;
      term = x;
      sum  = x;
      for (int unsigned n = 1; n <= pscg_pkg::TAYLOR_TERMS; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TaylorDiv[n-1];
        if (n[0]) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * SineAmp + (64'd1 << 29)) >> 30;
      if (v > SineAmp) begin
        v = SineAmp;
      end
      return v;
    end
  endfunction

  logic [MAG_W-1:0] qw [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam longint unsigned V = quarter_entry(k);
    assign qw[k] = V[MAG_W-1:0];
  end

  logic [1:0]       quad;
  logic [SC_W-1:0]  scaled;
  logic [IDX_W-1:0] idx_raw;
  logic [IDX_W-1:0] idx;
  logic [MAG_W-1:0] mag_q;
  logic             neg_q;
  logic [SAMPLE_BITS-1:0] mag_ext;

  assign quad    = phase_i[PHASE_BITS-1 -: 2];
  assign scaled  = SC_W'(phase_i[QW-1:0]) * SC_W'(SINE_TABLE_DEPTH);
  assign idx_raw = scaled[QW +: IDX_W];
  assign idx     = quad[0] ? IDX_W'(SINE_TABLE_DEPTH - 1) - idx_raw : idx_raw;

  always_ff @(posedge clk_i) begin
    mag_q <= qw[idx];
    neg_q <= quad[1];
  end

  assign mag_ext = {1'b0, mag_q};
  assign sine_o  = neg_q ? -$signed(mag_ext) : $signed(mag_ext);

endmodule

`default_nettype wire

// ===== src/pscg_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared unsigned multiplier with registered product.
module pscg_mul #(
  parameter int unsigned A_W = 17,
  parameter int unsigned B_W = 16
) (
  input  wire logic               clk_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0]      prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= (A_W + B_W)'(a_i) * (A_W + B_W)'(b_i);
  end

endmodule

`default_nettype wire

// ===== src/pulsed_sine_chord_generator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// An accepted request reaches out_valid_o after the sine and multiply states (later if the output is stalled).
// One request is worked on at a time, with four passes through the shared sine
// lookup (a request and an accumulate state each) and two passes through the shared multiplier.
// A finished sample waits in the output register while the next request is worked on.
// Reset (rst_ni low, async) clears the phase accumulators, the sequencer and output valid,
// and loads the register defaults.
module pulsed_sine_chord_generator_top #(
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              last_frame_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]          sample_o,
  output logic                                   sample_last_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pscg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pscg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned PB    = PHASE_BITS;
  localparam int unsigned CH_W  = SB + 2;
  localparam int unsigned A_W   = SB + 1;
  localparam int unsigned B_W   = (pscg_pkg::GAIN_W > SB - 1) ? pscg_pkg::GAIN_W : SB - 1;
  localparam int unsigned P_W   = A_W + B_W;
  localparam logic [A_W-1:0] Amp = A_W'((64'd1 << (SB - 1)) - 64'd1);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SIN_REQ   = 3'd1;
  localparam logic [2:0] ST_SIN_ACC   = 3'd2;
  localparam logic [2:0] ST_MUL_A     = 3'd3;
  localparam logic [2:0] ST_MUL_A_RES = 3'd4;
  localparam logic [2:0] ST_MUL_B     = 3'd5;
  localparam logic [2:0] ST_MUL_B_RES = 3'd6;

  localparam logic [1:0] SEL_PULSE = 2'd3;

  // Configuration registers
  logic [pscg_pkg::INC_W-1:0]  phase_inc_q;
  logic [pscg_pkg::INC_W-1:0]  pulse_inc_q;
  logic [pscg_pkg::GAIN_W-1:0] tone_gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= pscg_pkg::PHASE_INC_RST;
      pulse_inc_q <= pscg_pkg::PULSE_INC_RST;
      tone_gain_q <= pscg_pkg::TONE_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pscg_pkg::CFG_PHASE_INC: phase_inc_q <= cfg_data_i;
        pscg_pkg::CFG_PULSE_INC: pulse_inc_q <= cfg_data_i;
        pscg_pkg::CFG_TONE_GAIN: tone_gain_q <= cfg_data_i[pscg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath state
  logic [2:0]             state_q, state_d;
  logic [1:0]             sel_q;
  logic [PB-1:0]          tone_phase_q;
  logic [PB-1:0]          pulse_phase_q;
  logic signed [CH_W-1:0] chord_q;
  logic signed [SB-1:0]   ps_q;
  logic [A_W-1:0]         m_q;
  logic                   last_q;
  logic                   out_valid_q;
  logic signed [SB-1:0]   sample_q;
  logic                   sample_last_q;

  logic                   in_acc;
  logic                   out_free;
  logic                   load_out;
  logic [PB-1:0]          phase_sel;
  logic signed [SB-1:0]   sine;
  logic [A_W-1:0]         mul_a;
  logic [B_W-1:0]         mul_b;
  logic [P_W-1:0]         prod;
  logic                   chord_neg;
  logic                   ps_neg;
  logic                   neg;
  logic [CH_W-1:0]        chord_abs;
  logic [SB-2:0]          ps_abs;
  logic [P_W:0]           rnd1;
  logic [P_W:0]           rnd2;
  logic [A_W-1:0]         m2;
  logic [A_W-1:0]         m2_neg_ext;
  logic signed [SB-1:0]   sample_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == ST_MUL_B_RES) && out_free;

  // Tone angles 4a', 2a', 3a' in full-circle units, then the pulse phase
  always_comb begin
    case (sel_q)
      2'd0:    phase_sel = tone_phase_q << 2;
      2'd1:    phase_sel = tone_phase_q << 1;
      2'd2:    phase_sel = tone_phase_q + (tone_phase_q << 1);
      default: phase_sel = pulse_phase_q;
    endcase
  end

  pscg_sine #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_sine (
    .clk_i  (clk_i),
    .phase_i(phase_sel),
    .sine_o (sine)
  );

  assign chord_neg = chord_q[CH_W-1];
  assign ps_neg    = ps_q[SB-1];
  assign neg       = chord_neg ^ ps_neg;
  assign chord_abs = chord_neg ? CH_W'(-chord_q) : CH_W'(chord_q);
  assign ps_abs    = ps_neg ? (SB-1)'(-ps_q) : (SB-1)'(ps_q);

  // Multiplier operands stay put through the result state so a stalled output can wait
  always_comb begin
    if (state_q == ST_MUL_B || state_q == ST_MUL_B_RES) begin
      mul_a = m_q;
      mul_b = B_W'(ps_abs);
    end else begin
      mul_a = chord_abs[A_W-1:0];
      mul_b = B_W'(tone_gain_q);
    end
  end

  pscg_mul #(
    .A_W(A_W),
    .B_W(B_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // Round half away from zero on magnitudes, sign applied last
  assign rnd1       = {1'b0, prod} + (P_W + 1)'(32768);
  assign rnd2       = {1'b0, prod} + ((P_W + 1)'(1) << (SB - 2));
  assign m2         = rnd2[SB-1 +: A_W];
  assign m2_neg_ext = A_W'(-m2);

  always_comb begin
    if (neg) begin
      if (m2 > Amp + A_W'(1)) begin
        sample_d = {1'b1, {(SB-1){1'b0}}};
      end else begin
        sample_d = $signed(m2_neg_ext[SB-1:0]);
      end
    end else begin
      if (m2 > Amp) begin
        sample_d = $signed(Amp[SB-1:0]);
      end else begin
        sample_d = $signed(m2[SB-1:0]);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_acc) state_d = ST_SIN_REQ;
      ST_SIN_REQ:   state_d = ST_SIN_ACC;
      ST_SIN_ACC:   state_d = (sel_q == SEL_PULSE) ? ST_MUL_A : ST_SIN_REQ;
      ST_MUL_A:     state_d = ST_MUL_A_RES;
      ST_MUL_A_RES: state_d = ST_MUL_B;
      ST_MUL_B:     state_d = ST_MUL_B_RES;
      ST_MUL_B_RES: if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sel_q         <= 2'd0;
      tone_phase_q  <= '0;
      pulse_phase_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        sel_q <= 2'd0;
      end else if (state_q == ST_SIN_ACC) begin
        sel_q <= sel_q + 2'd1;
      end
      if (load_out) begin
        tone_phase_q  <= tone_phase_q + PB'(phase_inc_q);
        pulse_phase_q <= pulse_phase_q + PB'(pulse_inc_q);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      chord_q <= '0;
      last_q  <= last_frame_i;
    end else if (state_q == ST_SIN_ACC) begin
      if (sel_q == SEL_PULSE) begin
        ps_q <= sine;
      end else begin
        chord_q <= chord_q + CH_W'(sine);
      end
    end
    if (state_q == ST_MUL_A_RES) begin
      m_q <= rnd1[16 +: A_W];
    end
    if (load_out) begin
      sample_q      <= sample_d;
      sample_last_q <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_o      = sample_q;
  assign sample_last_o = sample_last_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SIN_REQ) && (sel_q == 2'd0))
    else $error("request did not start the sine sequence");

  a_pulse_then_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIN_ACC) && (sel_q == SEL_PULSE) |=> (state_q == ST_MUL_A))
    else $error("multiply did not follow the pulse sine");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_out |=> $stable(tone_phase_q) && $stable(pulse_phase_q))
    else $error("phase moved outside frame completion");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_o && (state_q == ST_IDLE))
    else $error("completed frame not presented");

  a_busy_no_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_B_RES) && out_valid_q && out_stall_i |=> (state_q == ST_MUL_B_RES))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// ===== test/pulsed_sine_chord_generator_top_test.sv =====
`timescale 1ns / 1ps

module pulsed_sine_chord_generator_top_test;

  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned SINE_DEPTH = 256;
  localparam int unsigned SAMPLE_W   = 16;
  localparam longint unsigned AMP    = (64'd1 << (SAMPLE_W - 1)) - 1;

  // index past the last register: the block must drop the write
  localparam logic [pscg_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } frame_t;

  class chord_tracker;
    longint unsigned quarter_wave[SINE_DEPTH];
    bit [31:0] phase_step;
    bit [31:0] pulse_step;
    bit [15:0] gain;
    bit [PHASE_W-1:0] tone_acc;
    bit [PHASE_W-1:0] pulse_acc;
    frame_t expected_frames[$];
    int failures;

    function new();
      longint unsigned x, term, sum, v;
      for (int k = 0; k < SINE_DEPTH; k++) begin
        x = (64'(2 * k + 1) * pscg_pkg::PI_Q30) / 64'(4 * SINE_DEPTH);
        term = x;
        sum = x;
        for (longint unsigned n = 1; n <= pscg_pkg::TAYLOR_TERMS; n++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / ((2 * n) * (2 * n + 1));
          if (n[0]) sum = (sum >= term) ? sum - term : 64'd0;
          else sum = sum + term;
        end
        v = (sum * AMP + (64'd1 << 29)) >> 30;
        if (v > AMP) v = AMP;
        quarter_wave[k] = v;
      end
      phase_step = pscg_pkg::PHASE_INC_RST;
      pulse_step = pscg_pkg::PULSE_INC_RST;
      gain = pscg_pkg::TONE_GAIN_RST;
      tone_acc = '0;
      pulse_acc = '0;
      failures = 0;
    endfunction

    function int sine_at(bit [PHASE_W-1:0] ph);
      bit [1:0] quad;
      longint unsigned idx;
      int mag;
      quad = ph[PHASE_W-1 -: 2];
      idx = (64'(ph[PHASE_W-3:0]) * SINE_DEPTH) >> (PHASE_W - 2);
      if (idx >= SINE_DEPTH) idx = SINE_DEPTH - 1;
      if (quad[0]) idx = SINE_DEPTH - 1 - idx;
      mag = int'(quarter_wave[idx]);
      return quad[1] ? -mag : mag;
    endfunction

    function void set_reg(logic [pscg_pkg::CFG_IDX_W-1:0] idx,
                          logic [pscg_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        pscg_pkg::CFG_PHASE_INC: phase_step = data;
        pscg_pkg::CFG_PULSE_INC: pulse_step = data;
        pscg_pkg::CFG_TONE_GAIN: gain = data[15:0];
        default: ;
      endcase
    endfunction

    function void add_frame(bit last);
      bit [PHASE_W-1:0] a2, a3, a4;
      int chord, pulse;
      bit neg;
      longint unsigned m, pm;
      frame_t f;
      a2 = tone_acc << 1;
      a3 = tone_acc * 3;
      a4 = tone_acc << 2;
      chord = sine_at(a4) + sine_at(a2) + sine_at(a3);
      pulse = sine_at(pulse_acc);
      neg = (chord < 0) != (pulse < 0);
      m = 64'((chord < 0) ? -chord : chord);
      pm = 64'((pulse < 0) ? -pulse : pulse);
      m = (m * gain + 64'd32768) >> 16;
      m = (m * pm + (64'd1 << (SAMPLE_W - 2))) >> (SAMPLE_W - 1);
      if (neg) begin
        if (m > AMP + 1) m = AMP + 1;
        f.sample = SAMPLE_W'(64'd0 - m);
      end else begin
        if (m > AMP) m = AMP;
        f.sample = SAMPLE_W'(m);
      end
      f.last = last;
      expected_frames.push_back(f);
      tone_acc = tone_acc + phase_step;
      pulse_acc = pulse_acc + pulse_step;
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] got, logic got_last);
      frame_t f;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected sample %0d last %0b", $time, got, got_last);
        failures++;
        return;
      end
      f = expected_frames.pop_front();
      if (got !== f.sample) begin
        $display("%0t: sample expected %0d got %0d", $time, f.sample, got);
        failures++;
      end
      if (got_last !== f.last) begin
        $display("%0t: sample_last expected %0b got %0b", $time, f.last, got_last);
        failures++;
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic last_frame_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_o;
  logic sample_last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pscg_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pscg_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  int unsigned idle_pct = 35;
  chord_tracker tracker = new();

  pulsed_sine_chord_generator_top #(
    .PHASE_BITS      (PHASE_W),
    .SINE_TABLE_DEPTH(SINE_DEPTH),
    .SAMPLE_BITS     (SAMPLE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .last_frame_i (last_frame_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_o     (sample_o),
    .sample_last_o(sample_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("pulsed_sine_chord_generator_top test failed");
    $finish;
  end

  // valid stays up between back-to-back requests; it only drops on a gap
  task automatic send_frame(input bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    last_frame_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    tracker.add_frame(last);
  endtask

  task automatic send_frames(input int n);
    for (int i = 0; i < n; i++) send_frame($urandom_range(1));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  task automatic write_reg(input logic [pscg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pscg_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(input logic [31:0] phase_inc, input logic [31:0] pulse_inc,
                       input logic [15:0] tone_gain);
    write_reg(pscg_pkg::CFG_PHASE_INC, phase_inc);
    write_reg(pscg_pkg::CFG_PULSE_INC, pulse_inc);
    write_reg(pscg_pkg::CFG_TONE_GAIN, {16'($urandom), tone_gain});
  endtask

  // biased toward the ends of the range
  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return '0;
    if (r < 4) return '1;
    return $urandom;
  endfunction

  initial begin : result_sink
    int unsigned accepted;
    int unsigned hold_left;
    bit held_once;
    accepted = 0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        tracker.check_sample(sample_o, sample_last_o);
        accepted++;
      end
      // long back-pressure so the block fills and stalls its input
      if (!held_once && accepted == 150) begin
        held_once = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults
    send_frame(1'b0);
    send_frame(1'b1);
    send_frame(1'b1);
    send_frame(1'b0);
    drain();

    // full gain, pulse stepping by quadrants: saturation at both signs
    setup(32'h0B00_0000, 32'h4000_0000, 16'hFFFF);
    send_frames(8);
    drain();

    // zero gain, all-ones steps wrap both accumulators
    setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
    send_frames(3);
    drain();

    write_reg(CFG_NO_REG, $urandom);
    setup(32'h8000_0000, 32'h0000_0000, 16'h0001);
    send_frames(4);
    drain();

    setup(32'h0000_0000, 32'h4000_0000, 16'h8000);
    send_frames(4);
    drain();

    for (int p = 0; p < 8; p++) begin
      idle_pct = (p == 3) ? 0 : 35;
      if ($urandom_range(2) == 0) write_reg(CFG_NO_REG, $urandom);
      setup(pick_word(), pick_word(), 16'(pick_word()));
      send_frames(55);
      drain();
    end
    idle_pct = 35;

    repeat (30) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("pulsed_sine_chord_generator_top test passed");
    end else begin
      $display("pulsed_sine_chord_generator_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pscg_pkg.sv
src/pscg_sine.sv
src/pscg_mul.sv
src/pulsed_sine_chord_generator_top.sv
test/pulsed_sine_chord_generator_top_test.sv
